// File: hdl/scts_pkg.sv
// Package for the sine/cosine series block: widths, datapath op codes, jump conditions
// and the microprogram read-only table.
// No dependencies; imported by every module of the block.
package scts_pkg;

   // Fixed number formats.
   localparam int FRAC_BITS = 28;
   localparam int ANGLE_W   = 31;
   localparam int VALUE_W   = 30;
   localparam int THR_W     = 10;
   // Term magnitude stays below 11.0 for any angle in the 31-bit range.
   localparam int MAG_W     = 32;
   // Partial sums stay below exp(4.0) in magnitude.
   localparam int ACC_W     = 36;
   localparam int PROD_W    = MAG_W + ANGLE_W;
   // Quotient and dividend width for the nibble-serial divider.
   localparam int DVD_W     = 36;
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = DVD_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Configuration register map (word index from paddr[2]).
   localparam int  CSR_ADDR_W = 3;
   localparam logic REG_THR   = 1'b0;

   // Datapath operations.
   localparam logic [2:0] OP_NOP    = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1;
   localparam logic [2:0] OP_MUL    = 3'd2;
   localparam logic [2:0] OP_DIV1   = 3'd3;
   localparam logic [2:0] OP_DIV2   = 3'd4;
   localparam logic [2:0] OP_DSTEP  = 3'd5;
   localparam logic [2:0] OP_ACC    = 3'd6;
   localparam logic [2:0] OP_FINISH = 3'd7;

   // Jump conditions: jump to target when true, else fall through.
   localparam logic [2:0] C_NONE     = 3'd0;
   localparam logic [2:0] C_ALWAYS   = 3'd1;
   localparam logic [2:0] C_NO_REQ   = 3'd2;
   localparam logic [2:0] C_STOP     = 3'd3;
   localparam logic [2:0] C_DIV_MORE = 3'd4;
   localparam logic [2:0] C_RSP_BUSY = 3'd5;

   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
   localparam logic [PC_W-1:0] PC_CHECK  = 4'd1;
   localparam logic [PC_W-1:0] PC_MUL1   = 4'd2;
   localparam logic [PC_W-1:0] PC_INIT1  = 4'd3;
   localparam logic [PC_W-1:0] PC_DIV1   = 4'd4;
   localparam logic [PC_W-1:0] PC_MUL2   = 4'd5;
   localparam logic [PC_W-1:0] PC_INIT2  = 4'd6;
   localparam logic [PC_W-1:0] PC_DIV2   = 4'd7;
   localparam logic [PC_W-1:0] PC_ACC    = 4'd8;
   localparam logic [PC_W-1:0] PC_FINISH = 4'd9;
   localparam logic [PC_W-1:0] PC_RETURN = 4'd10;

   typedef struct packed {
      logic [2:0]      op;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } uword_type;

   // Status flags the sequencer tests for its jumps.
   typedef struct packed {
      logic req_valid;
      logic rsp_busy;
      logic stop;
      logic div_more;
   } stat_type;

   // Microprogram: one control word per step.
   function automatic uword_type rom_word(input logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         PC_IDLE:   w = '{OP_LOAD,   C_NO_REQ,   PC_IDLE};
         PC_CHECK:  w = '{OP_NOP,    C_STOP,     PC_FINISH};
         PC_MUL1:   w = '{OP_MUL,    C_NONE,     PC_IDLE};
         PC_INIT1:  w = '{OP_DIV1,   C_NONE,     PC_IDLE};
         PC_DIV1:   w = '{OP_DSTEP,  C_DIV_MORE, PC_DIV1};
         PC_MUL2:   w = '{OP_MUL,    C_NONE,     PC_IDLE};
         PC_INIT2:  w = '{OP_DIV2,   C_NONE,     PC_IDLE};
         PC_DIV2:   w = '{OP_DSTEP,  C_DIV_MORE, PC_DIV2};
         PC_ACC:    w = '{OP_ACC,    C_ALWAYS,   PC_CHECK};
         PC_FINISH: w = '{OP_FINISH, C_RSP_BUSY, PC_FINISH};
         PC_RETURN: w = '{OP_NOP,    C_ALWAYS,   PC_IDLE};
         default:   w = '{OP_NOP,    C_ALWAYS,   PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// File: hdl/sine_cosine_taylor_series.sv
// Sine or cosine of a Q3.28 angle by the alternating Maclaurin series. Each item is
// worked by a microcoded sequencer on one multiplier and one divider that yields four
// quotient bits per cycle. An item runs 0 to MAX_TERMS-1 series steps, ending early once
// a term is at or below the threshold register: each step costs two multiplies and two
// nibble-serial divisions. A new transfer is taken once the previous result sits in the
// output register. Depends on scts_pkg, scts_seq, scts_dp and scts_div.
module sine_cosine_taylor_series #(
   parameter int MAX_TERMS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // [30:0] angle
   input  logic                            req_tuser,   // [0] opcode
   // Result channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [29:0] value
   // Configuration port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [scts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import scts_pkg::*;

   logic [THR_W-1:0]   thr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [VALUE_W-1:0] value;
   uword_type          uword;
   stat_type           stat;
   logic               accept;
   logic               rsp_load;
   logic               rsp_busy;
   logic               stop;
   logic               div_more;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_THR) ? {{(32 - THR_W){1'b0}}, thr_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_THR) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   // Handshake decode.
   assign req_tready = (uword.op == OP_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_load   = (uword.op == OP_FINISH) && !rsp_busy;

   assign stat = '{req_valid: req_tvalid, rsp_busy: rsp_busy, stop: stop,
                   div_more: div_more};

   scts_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .uword (uword)
   );

   scts_dp #(
      .MAX_TERMS (MAX_TERMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .uword     (uword),
      .load      (accept),
      .opcode    (req_tuser),
      .angle     (req_tdata[ANGLE_W-1:0]),
      .threshold (thr_ff),
      .stop      (stop),
      .div_more  (div_more),
      .value     (value)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - VALUE_W){1'b0}}, rsp_value_ff};

`ifndef ASSERT_OFF
   // The sequencer leaves the idle word right after taking an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("input still ready after a transfer");

   // A result is never loaded in the cycle that a new item is taken.
   a_no_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      !(accept && rsp_load))
      else $error("result load collides with an input transfer");

   // A held result lies within plus or minus one.
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_value_ff) <= $signed(VALUE_W'(1 << FRAC_BITS))
                        && $signed(rsp_value_ff) >= -$signed(VALUE_W'(1 << FRAC_BITS))))
      else $error("result outside plus or minus one");
`endif

endmodule

// File: hdl/scts_seq.sv
// Microcode sequencer: program counter, read-only control table and jump logic.
// Depends on scts_pkg.
module scts_seq (
   input  logic                clock,
   input  logic                reset,
   input  scts_pkg::stat_type  stat,
   output scts_pkg::uword_type uword
);
   import scts_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            take;

   assign uword = rom_word(pc_ff);

   // Evaluate the jump condition of the current word.
   always_comb begin
      case (uword.cond)
         C_NONE:     take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NO_REQ:   take = !stat.req_valid;
         C_STOP:     take = stat.stop;
         C_DIV_MORE: take = stat.div_more;
         C_RSP_BUSY: take = stat.rsp_busy;
         default:    take = 1'b1;
      endcase
      pc_in = take ? uword.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: hdl/scts_div.sv
// Unsigned iterative divider, four quotient bits per step, restoring form.
// Depends on scts_pkg; instantiated by scts_dp.
module scts_div #(
   parameter int DW = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       step,
   input  logic [scts_pkg::DVD_W-1:0] dividend,
   input  logic [DW-1:0]              divisor,
   output logic [scts_pkg::DVD_W-1:0] quot_next,
   output logic                       last
);
   import scts_pkg::*;

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DW:0]          trial;
   logic [DW-1:0]        r;
   logic [DVD_W-1:0]     q;

   // Four shift-and-subtract steps; quotient bits enter the low end of the dividend.
   always_comb begin
      r = rem_ff;
      q = dvd_ff;
      trial = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {r, q[DVD_W-1]};
         q = {q[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial = trial - {1'b0, den_ff};
            q[0] = 1'b1;
         end
         r = trial[DW-1:0];
      end
      dvd_in = q;
      rem_in = r;
   end

   assign quot_next = dvd_in;
   assign last      = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= '0;
      end else if (step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

endmodule

// File: hdl/scts_dp.sv
// Datapath: term magnitude, shared multiplier, divider, accumulator and output clamp.
// Depends on scts_pkg and scts_div.
module scts_dp #(
   parameter int MAX_TERMS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  scts_pkg::uword_type          uword,
   input  logic                         load,
   input  logic                         opcode,
   input  logic [scts_pkg::ANGLE_W-1:0] angle,
   input  logic [scts_pkg::THR_W-1:0]   threshold,
   output logic                         stop,
   output logic                         div_more,
   output logic [scts_pkg::VALUE_W-1:0] value
);
   import scts_pkg::*;

   localparam int NW = $clog2(MAX_TERMS + 1);
   localparam int DW = NW + 1;
   localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) <<< FRAC_BITS;

   logic                    cos_ff, cos_in;
   logic                    xneg_ff, xneg_in;
   logic [ANGLE_W-1:0]      ax_ff, ax_in;
   logic [MAG_W-1:0]        m_ff, m_in;
   logic signed [ACC_W-1:0] total_ff, total_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [NW-1:0]           n_ff, n_in;
   logic [ANGLE_W-1:0]      mag;
   logic                    neg;
   logic [DW-1:0]           d1;
   logic [DW-1:0]           divisor;
   logic                    div_start;
   logic                    div_step;
   logic [DVD_W-1:0]        quot_next;
   logic                    div_last;

   assign mag = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;
   assign neg = n_ff[0] ^ (!cos_ff && xneg_ff);
   assign d1  = {n_ff, 1'b0};

   // Second divisor is 2n-1 for cosine and 2n+1 for sine.
   always_comb begin
      if (uword.op == OP_DIV1) begin
         divisor = d1;
      end else if (cos_ff) begin
         divisor = d1 - 1'b1;
      end else begin
         divisor = d1 + 1'b1;
      end
   end

   assign div_start = (uword.op == OP_DIV1) || (uword.op == OP_DIV2);
   assign div_step  = (uword.op == OP_DSTEP);

   scts_div #(
      .DW (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .step      (div_step),
      .dividend  ({1'b0, prod_ff[PROD_W-1:FRAC_BITS]}),
      .divisor   (divisor),
      .quot_next (quot_next),
      .last      (div_last)
   );

   // Register updates by datapath operation.
   always_comb begin
      cos_in   = cos_ff;
      xneg_in  = xneg_ff;
      ax_in    = ax_ff;
      m_in     = m_ff;
      total_in = total_ff;
      prod_in  = prod_ff;
      n_in     = n_ff;
      case (uword.op)
         OP_LOAD: begin
            if (load) begin
               cos_in  = opcode;
               xneg_in = angle[ANGLE_W-1];
               ax_in   = mag;
               n_in    = NW'(1);
               if (opcode) begin
                  m_in     = MAG_W'(ONE);
                  total_in = ONE;
               end else begin
                  m_in = MAG_W'(mag);
                  total_in = angle[ANGLE_W-1] ? -$signed(ACC_W'(mag)) : $signed(ACC_W'(mag));
               end
            end
         end
         OP_MUL: begin
            prod_in = PROD_W'(m_ff) * PROD_W'(ax_ff);
         end
         OP_DSTEP: begin
            if (div_last) begin
               m_in = quot_next[MAG_W-1:0];
            end
         end
         OP_ACC: begin
            total_in = neg ? total_ff - $signed(ACC_W'(m_ff))
                           : total_ff + $signed(ACC_W'(m_ff));
            n_in = n_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_ff   <= cos_in;
      xneg_ff  <= xneg_in;
      ax_ff    <= ax_in;
      m_ff     <= m_in;
      total_ff <= total_in;
      prod_ff  <= prod_in;
      n_ff     <= n_in;
   end

   // Status for the sequencer.
   assign stop     = (m_ff <= MAG_W'(threshold)) || (n_ff == NW'(MAX_TERMS));
   assign div_more = !div_last;

   // Clamp the sum to plus or minus one.
   always_comb begin
      if (total_ff > ONE) begin
         value = VALUE_W'(ONE);
      end else if (total_ff < -ONE) begin
         value = VALUE_W'(-ONE);
      end else begin
         value = total_ff[VALUE_W-1:0];
      end
   end

endmodule
